// File: hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants for the cartesian to spherical converter
// Angle constants in units of 2^-24 rad, CORDIC arctangent table in 2^-32 rad.
// ----------------------------------------------------------------------------
package cts_pkg;

	localparam int CoordW = 32;
	localparam int ThetaW = 26;
	localparam int PhiW   = 29;
	localparam int CorW   = 44;   // cordic x/y datapath
	localparam int AccW   = 34;   // angle accumulator, 2^-32 rad

	localparam logic signed [PhiW-1:0] PiQ24        = 29'sd52707179;
	localparam logic signed [PhiW-1:0] HalfPiQ24    = 29'sd26353589;
	localparam logic signed [PhiW:0]   OneHalfPiQ24 = 30'sd79060768;
	localparam logic signed [PhiW:0]   TwoPiQ24     = 30'sd105414357;

	// one queued point between front and back
	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic                     first;
	} point_t;

	// atan(2^-i) in units of 2^-32 rad
	function automatic logic [AccW-1:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd3373259426; 5'd1:  v = 32'd1991351318;
			5'd2:  v = 32'd1052175346; 5'd3:  v = 32'd534100635;
			5'd4:  v = 32'd268086748;  5'd5:  v = 32'd134174063;
			5'd6:  v = 32'd67103403;   5'd7:  v = 32'd33553749;
			5'd8:  v = 32'd16777131;   5'd9:  v = 32'd8388597;
			5'd10: v = 32'd4194303;    5'd11: v = 32'd2097152;
			5'd12: v = 32'd1048576;    5'd13: v = 32'd524288;
			5'd14: v = 32'd262144;     5'd15: v = 32'd131072;
			5'd16: v = 32'd65536;      5'd17: v = 32'd32768;
			5'd18: v = 32'd16384;      5'd19: v = 32'd8192;
			5'd20: v = 32'd4096;       5'd21: v = 32'd2048;
			5'd22: v = 32'd1024;       5'd23: v = 32'd512;
			5'd24: v = 32'd256;        5'd25: v = 32'd128;
			5'd26: v = 32'd64;         5'd27: v = 32'd32;
			5'd28: v = 32'd16;         5'd29: v = 32'd8;
			5'd30: v = 32'd4;          default: v = 32'd2;
		endcase
		return {2'b00, v};
	endfunction

endpackage

// File: hdl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front: input side
// Accepts point words and keeps them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cts_pkg::point_t      in_point,
	output logic                 q_valid,
	input  logic                 q_ready,
	output cts_pkg::point_t      q_point
);

	cts_pkg::point_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_point  = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_point;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");

endmodule

// File: hdl/cts_sqrt.sv
// ----------------------------------------------------------------------------
// cts_sqrt: iterative integer square root
// Restoring digit recurrence, one result bit per cycle over a 66-bit radicand.
// ----------------------------------------------------------------------------
module cts_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] rad,
	output logic        done,
	output logic [32:0] root
);

	logic [65:0] rem_q;
	logic [32:0] acc_q;
	logic [32:0] res_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [34:0] trial;
	logic [34:0] part;

	assign part  = {acc_q, rem_q[65:64]};
	assign trial = part - {res_q[32:0], 2'b01} ;
	assign root  = res_q;
	assign done  = busy_q && (cnt_q == 6'd0);

	// restoring digit recurrence, one bit each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd33;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end

	// remainder stays below 2^33 for radicands under 2^64
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rad;
			acc_q <= '0;
			res_q <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			rem_q <= {rem_q[63:0], 2'b00};
			if (!trial[34]) begin
				acc_q <= trial[32:0];
				res_q <= {res_q[31:0], 1'b1};
			end else begin
				acc_q <= part[32:0];
				res_q <= {res_q[31:0], 1'b0};
			end
		end
	end

endmodule

// File: hdl/cts_cordic.sv
// ----------------------------------------------------------------------------
// cts_cordic: iterative atan2 by CORDIC vectoring
// Normalizes magnitudes, then one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module cts_cordic #(
	parameter int Steps = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [34:0]                   ya,
	input  logic signed [34:0]                   xa,
	output logic                                 done,
	output logic signed [cts_pkg::PhiW-1:0]      angle
);

	localparam int Cw = cts_pkg::CorW;
	localparam int Aw = cts_pkg::AccW;
	localparam int NSteps = (Steps > 32) ? 32 : Steps;
	localparam int PhiW_l = cts_pkg::PhiW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_NORM = 4'b0010, S_ITER = 4'b0100, S_FIN = 4'b1000
	} st_t;

	st_t st_q;
	logic signed [Cw-1:0] cx_q, cy_q;
	logic signed [Aw-1:0] acc_q;
	logic [5:0] i_q;
	logic xneg_q, yneg_q, zero_q;
	logic signed [PhiW_l-1:0] ang_q;
	logic [34:0] ux, uy;
	logic signed [Cw-1:0] dx, dy;
	logic signed [Aw-1:0] a_r;
	logic signed [PhiW_l:0] a_c, a_f;
	logic [Cw-1:0] mx;

	assign ux = xa[34] ? 35'(-xa) : 35'(xa);
	assign uy = ya[34] ? 35'(-ya) : 35'(ya);
	assign dx = cy_q >>> i_q[4:0];
	assign dy = cx_q >>> i_q[4:0];
	assign mx = (cx_q > cy_q) ? cx_q : cy_q;
	assign a_r = (acc_q + Aw'(128)) >>> 8;
	assign done  = (st_q == S_FIN);
	assign angle = ang_q;

	// final rounding, clamp and quadrant fold
	always_comb begin
		if (a_r < 0) a_c = '0;
		else if (a_r > Aw'(cts_pkg::HalfPiQ24)) a_c = (PhiW_l+1)'(cts_pkg::HalfPiQ24);
		else a_c = a_r[PhiW_l:0];
		a_f = xneg_q ? (PhiW_l+1)'(cts_pkg::PiQ24) - a_c : a_c;
		if (yneg_q) a_f = -a_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: if (start) st_q <= S_NORM;
				S_NORM: if (zero_q || mx[40]) st_q <= S_ITER;
				S_ITER: if (zero_q || i_q == 6'(NSteps)) st_q <= S_FIN;
				S_FIN:  st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath: normalize one bit a cycle, then rotate
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				cx_q   <= Cw'(ux);
				cy_q   <= Cw'(uy);
				xneg_q <= xa[34];
				yneg_q <= ya[34];
				zero_q <= (ux == '0) && (uy == '0);
				acc_q  <= '0;
				i_q    <= '0;
			end
			S_NORM: if (!zero_q && !mx[40]) begin
				cx_q <= cx_q <<< 1;
				cy_q <= cy_q <<< 1;
			end
			S_ITER: if (i_q != 6'(NSteps)) begin
				i_q <= i_q + 6'd1;
				if (cy_q >= 0) begin
					cx_q  <= cx_q + dx;
					cy_q  <= cy_q - dy;
					acc_q <= acc_q + cts_pkg::atan_lut(i_q[4:0]);
				end else begin
					cx_q  <= cx_q - dx;
					cy_q  <= cy_q + dy;
					acc_q <= acc_q - cts_pkg::atan_lut(i_q[4:0]);
				end
			end
			S_FIN: ;
			default: ;
		endcase
		if (st_q == S_ITER && (zero_q || i_q == 6'(NSteps)))
			ang_q <= zero_q ? '0 : a_f[PhiW_l-1:0];
	end

endmodule

// File: hdl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back: conversion engine
// Squares, two square roots, two CORDIC passes, azimuth unwrap, output register.
// ----------------------------------------------------------------------------
module cts_back #(
	parameter int Steps = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  cts_pkg::point_t                   q_point,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       range_rho,
	output logic [cts_pkg::ThetaW-1:0]        polar_theta,
	output logic signed [cts_pkg::PhiW-1:0]   azimuth_phi
);

	localparam int Pw = cts_pkg::PhiW;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001, B_SQ = 7'b0000010, B_SXY = 7'b0000100,
		B_RXY = 7'b0001000, B_RHO = 7'b0010000, B_ANG = 7'b0100000,
		B_OUT = 7'b1000000
	} bst_t;

	bst_t st_q;
	cts_pkg::point_t pt_q;
	logic [63:0] sqx_q, sqy_q, sqz_q;
	logic [32:0] rxy_q;
	logic [31:0] rho_q;
	logic sq_start, sq_done, co_start, th_done, ph_done, th_seen_q, ph_seen_q;
	logic [65:0] sq_rad;
	logic [32:0] sq_root;
	logic signed [Pw-1:0] th_ang, ph_ang, th_q, ph_q, last_q;
	logic signed [Pw+1:0] diff, phu;
	logic [31:0] ax, ay, az;

	assign ax = pt_q.pos_x[31] ? 32'(-pt_q.pos_x) : 32'(pt_q.pos_x);
	assign ay = pt_q.pos_y[31] ? 32'(-pt_q.pos_y) : 32'(pt_q.pos_y);
	assign az = pt_q.pos_z[31] ? 32'(-pt_q.pos_z) : 32'(pt_q.pos_z);
	assign q_ready = (st_q == B_IDLE);
	assign sq_rad  = (st_q == B_SXY) ? {1'b0, 65'({1'b0, sqx_q} + {1'b0, sqy_q})}
		: 66'({2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q});
	assign sq_start = (st_q == B_SXY) || (st_q == B_RXY && sq_done);
	assign co_start = (st_q == B_RHO) && sq_done;

	// unwrap against previous azimuth
	always_comb begin
		diff = (Pw+2)'(ph_q) - (Pw+2)'(last_q);
		phu  = (Pw+2)'(ph_q);
		if (!pt_q.first) begin
			priority if (diff > (Pw+2)'(cts_pkg::OneHalfPiQ24))
				phu = (Pw+2)'(ph_q) - (Pw+2)'(cts_pkg::TwoPiQ24);
			else if (diff < -(Pw+2)'(cts_pkg::OneHalfPiQ24))
				phu = (Pw+2)'(ph_q) + (Pw+2)'(cts_pkg::TwoPiQ24);
		end
	end

	cts_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .rad(sq_rad),
		.done(sq_done), .root(sq_root));

	cts_cordic #(.Steps(Steps)) u_theta (.clk, .arst_n, .start(co_start),
		.ya({2'b00, rxy_q}), .xa({{3{pt_q.pos_z[31]}}, pt_q.pos_z}),
		.done(th_done), .angle(th_ang));

	cts_cordic #(.Steps(Steps)) u_phi (.clk, .arst_n, .start(co_start),
		.ya({{3{pt_q.pos_y[31]}}, pt_q.pos_y}), .xa({{3{pt_q.pos_x[31]}}, pt_q.pos_x}),
		.done(ph_done), .angle(ph_ang));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			out_valid <= 1'b0;
			last_q    <= '0;
			th_seen_q <= 1'b0;
			ph_seen_q <= 1'b0;
		end else begin
			unique case (st_q)
				B_IDLE: if (q_valid) st_q <= B_SQ;
				B_SQ:   st_q <= B_SXY;
				B_SXY:  st_q <= B_RXY;
				B_RXY:  if (sq_done) st_q <= B_RHO;
				B_RHO:  if (sq_done) begin
					st_q <= B_ANG;
					th_seen_q <= 1'b0;
					ph_seen_q <= 1'b0;
				end
				B_ANG: begin
					if (th_done) th_seen_q <= 1'b1;
					if (ph_done) ph_seen_q <= 1'b1;
					if ((th_seen_q || th_done) && (ph_seen_q || ph_done) && !out_valid)
						st_q <= B_OUT;
				end
				B_OUT: begin
					out_valid <= 1'b1;
					last_q    <= phu[Pw-1:0];
					st_q      <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
			if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	// payload, result word held until taken
	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && q_valid) pt_q <= q_point;
		if (st_q == B_SQ) begin
			sqx_q <= ax * ax;
			sqy_q <= ay * ay;
			sqz_q <= az * az;
		end
		if (st_q == B_RXY && sq_done) rxy_q <= sq_root;
		if (st_q == B_RHO && sq_done) rho_q <= sq_root[31:0];
		if (th_done) th_q <= th_ang;
		if (ph_done) ph_q <= ph_ang;
		if (st_q == B_OUT) begin
			range_rho   <= rho_q;
			polar_theta <= th_q[cts_pkg::ThetaW-1:0];
			azimuth_phi <= phu[Pw-1:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_OUT |-> !out_valid || out_ready) else $error("result overwritten");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		co_start |-> !th_done && !ph_done) else $error("cordic restarted while done");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> st_q == B_IDLE) else $error("point taken while busy");

endmodule

// File: hdl/cartesian_to_spherical_unwrap.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_unwrap: lidar point to range, polar angle, azimuth
// Each point holds the engine through setup and squaring, the two bit-serial
// square roots one after the other, then the normalize, rotate and finish steps
// in the two parallel CORDIC units, and a last step to load the result.
// Small coordinates
// need the most normalize cycles, a point at the origin skips them. The input
// queue holds two points so the source keeps streaming while the engine
// works; the result register frees the engine while the sink stalls.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_unwrap #(
	parameter int CORDIC_STEPS = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // pos_x, pos_y, pos_z
	input  logic         s_tuser,   // first_of_scan
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata    // range_rho, polar_theta, azimuth_phi, zero pad
);

	cts_pkg::point_t in_pt, q_pt;
	logic q_valid, q_ready;
	logic [31:0] rho;
	logic [cts_pkg::ThetaW-1:0] theta;
	logic signed [cts_pkg::PhiW-1:0] phi;

	// unpack input word
	always_comb begin
		in_pt.pos_x = s_tdata[31:0];
		in_pt.pos_y = s_tdata[63:32];
		in_pt.pos_z = s_tdata[95:64];
		in_pt.first = s_tuser;
	end

	cts_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_point(in_pt), .q_valid, .q_ready, .q_point(q_pt));

	cts_back #(.Steps(CORDIC_STEPS)) u_back (.clk, .arst_n, .q_valid, .q_ready,
		.q_point(q_pt), .out_valid(m_tvalid), .out_ready(m_tready),
		.range_rho(rho), .polar_theta(theta), .azimuth_phi(phi));

	// pack result word
	assign m_tdata = {1'b0, phi, theta, rho};

endmodule
